// File: hw/rtl/xbr_pkg.sv
// ----------------------------------------------------------------------------
// xbr_pkg
// Shared types, codes and the CRC-16 byte update for the XMODEM block receiver.
// ----------------------------------------------------------------------------
package xbr_pkg;

  // Block geometry
  localparam int BLOCK_BYTES = 128;
  localparam int IDX_W       = $clog2(BLOCK_BYTES + 5);
  localparam logic [IDX_W-1:0] DATA_END = IDX_W'(3 + BLOCK_BYTES);

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Line bytes
  localparam logic [7:0]  SOH_BYTE = 8'h01;
  localparam logic [7:0]  EOT_BYTE = 8'h04;
  localparam logic [7:0]  HDR_SUM  = 8'hFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Send codes
  localparam logic [2:0] SEND_NONE = 3'd0;
  localparam logic [2:0] SEND_C    = 3'd1;
  localparam logic [2:0] SEND_NAK  = 3'd2;
  localparam logic [2:0] SEND_ACK  = 3'd3;
  localparam logic [2:0] SEND_CAN  = 3'd4;

  // Status codes
  localparam logic [2:0] ST_BUSY       = 3'd0;
  localparam logic [2:0] ST_OK         = 3'd1;
  localparam logic [2:0] ST_NO_EOT     = 3'd2;
  localparam logic [2:0] ST_UNEXPECTED = 3'd3;
  localparam logic [2:0] ST_SYNC       = 3'd4;

  // Input action codes
  localparam logic ACT_START = 1'b0;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT,
    PH_BLOCK,
    PH_AFTER_EOT,
    PH_END
  } phase_t;

  // Front-end classification of an item
  typedef enum logic [1:0] {
    K_START,
    K_SOH,
    K_EOT,
    K_OTHER
  } kind_t;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] send_code;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       block_end;
    logic       block_commit;
    logic [2:0] status;
  } result_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] rx_byte;
  } cmd_t;

  // Queue handshake toward the front
  typedef struct packed {
    logic full;
    logic push;
  } q_stat_t;

  // CRC-16, poly 0x1021, one byte, MSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/xmodem_block_receiver.sv
// Path: an item passes through the input stage, the queue and the result register.
// Throughput: one item per cycle while item_stall is low; the protocol engine steps one byte per cycle
// while the result is not stalled, CRC-16 byte update included, and the 4-entry queue absorbs result-side stalls.
// Reset: synchronous; clears the queue, the state machine (idle) and sets use_crc to 1.
// ----------------------------------------------------------------------------
// xmodem_block_receiver
// XMODEM receiver: classifies line bytes in front, runs the block protocol in back.
// ----------------------------------------------------------------------------
module xmodem_block_receiver (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             item_valid,
  output logic             item_stall,
  input  xbr_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output xbr_pkg::result_t result
);
  import xbr_pkg::*;

  logic    fe_valid;
  cmd_t    fe_cmd;
  q_stat_t qstat;
  logic    q_valid;
  cmd_t    q_cmd;
  logic    q_ready;

  xbr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cmd_valid  (fe_valid),
    .cmd        (fe_cmd),
    .q_full     (qstat.full)
  );

  xbr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fe_valid),
    .push_cmd   (fe_cmd),
    .qstat      (qstat),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd),
    .pop_ready  (q_ready)
  );

  xbr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd_valid    (q_valid),
    .cmd          (q_cmd),
    .cmd_ready    (q_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Assertions
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    qstat.push |-> !qstat.full)
    else $error("queue push while full");

  a_commit_at_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.block_commit |-> result.block_end &&
      result.send_code == SEND_ACK)
    else $error("commit without block end and ACK");

  a_data_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.data_valid |-> result.send_code == SEND_NONE &&
      !result.block_end)
    else $error("data byte together with a control response");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

// File: hw/rtl/xbr_front.sv
// ----------------------------------------------------------------------------
// xbr_front
// Input stage: takes item transfers, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
module xbr_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  xbr_pkg::item_t item,
  output logic           cmd_valid,
  output xbr_pkg::cmd_t  cmd,
  input  logic           q_full
);
  import xbr_pkg::*;

  logic  fe_valid;
  cmd_t  fe_cmd;
  cmd_t  cls;
  logic  load;

  // Classify the incoming item
  always_comb begin
    cls.rx_byte = item.rx_byte;
    if (item.action == ACT_START) begin
      cls.kind = K_START;
    end else if (item.rx_byte == SOH_BYTE) begin
      cls.kind = K_SOH;
    end else if (item.rx_byte == EOT_BYTE) begin
      cls.kind = K_EOT;
    end else begin
      cls.kind = K_OTHER;
    end
  end

  // Hold off only while the stage is full and the queue cannot take it
  assign item_stall = fe_valid && q_full;
  assign load       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      fe_valid <= 1'b0;
    end else if (load) begin
      fe_valid <= 1'b1;
    end else if (!q_full) begin
      fe_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fe_cmd <= cls;
    end
  end

  assign cmd_valid = fe_valid;
  assign cmd       = fe_cmd;

endmodule

// File: hw/rtl/xbr_queue.sv
// ----------------------------------------------------------------------------
// xbr_queue
// Short FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module xbr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  xbr_pkg::cmd_t    push_cmd,
  output xbr_pkg::q_stat_t qstat,
  output logic             pop_valid,
  output xbr_pkg::cmd_t    pop_cmd,
  input  logic             pop_ready
);
  import xbr_pkg::*;

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              full;
  logic              push;
  logic              pop;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign push      = push_valid && !full;
  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_cmd   = mem[rd_ptr];

  assign qstat.full = full;
  assign qstat.push = push;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: hw/rtl/xbr_back.sv
// ----------------------------------------------------------------------------
// xbr_back
// Protocol engine: block framing, check, sequencing and the result register.
// ----------------------------------------------------------------------------
module xbr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             cmd_valid,
  input  xbr_pkg::cmd_t    cmd,
  output logic             cmd_ready,
  output logic             result_valid,
  input  logic             result_stall,
  output xbr_pkg::result_t result
);
  import xbr_pkg::*;

  logic             use_crc;
  phase_t           phase, phase_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [7:0]       got_number, got_number_next;
  logic             header_bad, header_bad_next;
  logic             is_new_block, is_new_block_next;
  logic [7:0]       last_good_number, last_good_number_next;
  logic [15:0]      check_accum, check_accum_next;
  logic [7:0]       check_high_byte, check_high_byte_next;
  result_t          res_next;
  result_t          res_q;
  logic             res_valid;
  logic             step;
  logic [7:0]       next_num;
  logic [7:0]       b;
  logic             good;
  logic             hdr_bad_now;

  assign cmd_ready = !res_valid || !result_stall;
  assign step      = cmd_valid && cmd_ready;
  assign b         = cmd.rx_byte;
  assign next_num  = last_good_number + 8'd1;
  assign hdr_bad_now = (got_number + b) != HDR_SUM;

  // Check comparison at the final byte
  always_comb begin
    if (use_crc) begin
      good = (check_accum == {check_high_byte, b});
    end else begin
      good = (check_accum[7:0] == b);
    end
  end

  // Next state and result
  always_comb begin
    phase_next            = phase;
    byte_index_next       = byte_index;
    got_number_next       = got_number;
    header_bad_next       = header_bad;
    is_new_block_next     = is_new_block;
    last_good_number_next = last_good_number;
    check_accum_next      = check_accum;
    check_high_byte_next  = check_high_byte;
    res_next              = '0;
    res_next.send_code    = SEND_NONE;
    res_next.status       = ST_BUSY;

    if (cmd.kind == K_START) begin
      phase_next            = PH_WAIT;
      byte_index_next       = '0;
      got_number_next       = '0;
      header_bad_next       = 1'b0;
      is_new_block_next     = 1'b0;
      last_good_number_next = '0;
      check_accum_next      = '0;
      check_high_byte_next  = '0;
      res_next.send_code    = use_crc ? SEND_C : SEND_NAK;
    end else begin
      unique case (phase)
        PH_WAIT: begin
          if (cmd.kind == K_SOH) begin
            phase_next      = PH_BLOCK;
            byte_index_next = IDX_W'(1);
          end else if (cmd.kind == K_EOT) begin
            res_next.send_code = SEND_NAK;
            phase_next         = PH_AFTER_EOT;
          end else begin
            res_next.send_code = SEND_CAN;
            res_next.status    = ST_NO_EOT;
            phase_next         = PH_END;
          end
        end
        PH_AFTER_EOT: begin
          if (cmd.kind == K_EOT) begin
            res_next.send_code = SEND_ACK;
            res_next.status    = ST_OK;
          end else begin
            res_next.status = ST_UNEXPECTED;
          end
          phase_next = PH_END;
        end
        PH_BLOCK: begin
          if (byte_index <= IDX_W'(1)) begin
            // block number
            got_number_next = b;
            byte_index_next = IDX_W'(2);
          end else if (byte_index == IDX_W'(2)) begin
            // complement of the block number
            header_bad_next   = hdr_bad_now;
            is_new_block_next = !hdr_bad_now && (got_number == next_num);
            check_accum_next  = '0;
            byte_index_next   = IDX_W'(3);
          end else if (byte_index < DATA_END) begin
            // data byte
            if (use_crc) begin
              check_accum_next = crc_update(check_accum, b);
            end else begin
              check_accum_next = {8'h00, check_accum[7:0] + b};
            end
            res_next.data_valid = is_new_block;
            res_next.data_byte  = is_new_block ? b : 8'h00;
            byte_index_next     = byte_index + 1'b1;
          end else if (use_crc && byte_index == DATA_END) begin
            check_high_byte_next = b;
            byte_index_next      = byte_index + 1'b1;
          end else begin
            // block decision
            res_next.block_end = 1'b1;
            phase_next         = PH_WAIT;
            byte_index_next    = '0;
            if (header_bad) begin
              res_next.send_code = SEND_NAK;
            end else if (got_number != next_num && got_number != last_good_number) begin
              res_next.send_code = SEND_CAN;
              res_next.status    = ST_SYNC;
              phase_next         = PH_END;
            end else if (!good) begin
              res_next.send_code = SEND_NAK;
            end else begin
              res_next.send_code = SEND_ACK;
              if (is_new_block) begin
                res_next.block_commit = 1'b1;
                last_good_number_next = next_num;
              end
            end
          end
        end
        PH_IDLE, PH_END: begin
          // bytes are ignored
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      use_crc <= 1'b1;
    end else if (cfg_we) begin
      use_crc <= cfg_wdata;
    end
  end

  // Protocol state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      byte_index       <= '0;
      got_number       <= '0;
      header_bad       <= 1'b0;
      is_new_block     <= 1'b0;
      last_good_number <= '0;
      check_accum      <= '0;
      check_high_byte  <= '0;
    end else if (step) begin
      phase            <= phase_next;
      byte_index       <= byte_index_next;
      got_number       <= got_number_next;
      header_bad       <= header_bad_next;
      is_new_block     <= is_new_block_next;
      last_good_number <= last_good_number_next;
      check_accum      <= check_accum_next;
      check_high_byte  <= check_high_byte_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (!result_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res_next;
    end
  end

  assign result_valid = res_valid;
  assign result       = res_q;

endmodule

// File: tb/xmodem_rx_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xmodem_rx_checker
// Watches the item, result and check-mode ports of the XMODEM block receiver.
// Keeps its own copy of the receiver protocol state, predicts one reply per
// accepted line item and compares replies field by field in transfer order.
// ----------------------------------------------------------------------------
module xmodem_rx_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             item_valid,
  input  logic             item_stall,
  input  xbr_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  xbr_pkg::result_t result,
  input  logic             run_done,
  output int               pending,
  output int               fail_count,
  output int               commits
);
  import xbr_pkg::*;

  localparam logic [15:0] DATA_LAST = 16'(3 + BLOCK_BYTES);
  localparam int          MAX_PRINT = 50;

  // Shadow of the receiver state
  logic        crc_mode;
  phase_t      ph;
  logic [15:0] pos;
  logic [7:0]  blk_num;
  logic        hdr_bad;
  logic        fresh;
  logic [7:0]  last_ok;
  logic [15:0] chk;
  logic [7:0]  chk_hi;

  result_t reply_q[$];
  int      n_replies;
  logic    end_checked;

  // CRC-16, poly 0x1021, init 0, one data bit at a time, MSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  task automatic clear_transfer();
    ph      = PH_WAIT;
    pos     = '0;
    blk_num = '0;
    hdr_bad = 1'b0;
    fresh   = 1'b0;
    last_ok = '0;
    chk     = '0;
    chk_hi  = '0;
  endtask

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINT) begin
      $display("[%0t] reply %0d: %s", $time, n_replies, msg);
    end
    fail_count++;
  endtask

  task automatic cmp_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // One protocol step: the reply that one line item causes
  task automatic predict_reply(input item_t it, output result_t r);
    logic [7:0] b;
    logic [7:0] want_num;
    logic       good;
    b           = it.rx_byte;
    want_num    = last_ok + 8'd1;
    r           = '0;
    r.send_code = SEND_NONE;
    r.status    = ST_BUSY;
    if (it.action == ACT_START) begin
      clear_transfer();
      r.send_code = crc_mode ? SEND_C : SEND_NAK;
    end else begin
      case (ph)
        PH_WAIT: begin
          if (b == SOH_BYTE) begin
            ph  = PH_BLOCK;
            pos = 16'd1;
          end else if (b == EOT_BYTE) begin
            r.send_code = SEND_NAK;
            ph          = PH_AFTER_EOT;
          end else begin
            r.send_code = SEND_CAN;
            r.status    = ST_NO_EOT;
            ph          = PH_END;
          end
        end
        PH_AFTER_EOT: begin
          if (b == EOT_BYTE) begin
            r.send_code = SEND_ACK;
            r.status    = ST_OK;
          end else begin
            r.status = ST_UNEXPECTED;
          end
          ph = PH_END;
        end
        PH_BLOCK: begin
          if (pos <= 16'd1) begin
            blk_num = b;
            pos     = 16'd2;
          end else if (pos == 16'd2) begin
            hdr_bad = (9'(blk_num) + 9'(b)) != 9'(HDR_SUM);
            fresh   = !hdr_bad && (blk_num == want_num);
            chk     = '0;
            pos     = 16'd3;
          end else if (pos < DATA_LAST) begin
            // check mode is taken live on every byte
            chk          = crc_mode ? crc16_step(chk, b) : {8'h00, chk[7:0] + b};
            r.data_valid = fresh;
            r.data_byte  = fresh ? b : 8'h00;
            pos          = pos + 16'd1;
          end else if (crc_mode && pos == DATA_LAST) begin
            chk_hi = b;
            pos    = pos + 16'd1;
          end else begin
            // final check byte: decide the block
            good        = crc_mode ? (chk == {chk_hi, b}) : (chk[7:0] == b);
            r.block_end = 1'b1;
            ph          = PH_WAIT;
            pos         = '0;
            if (hdr_bad) begin
              r.send_code = SEND_NAK;
            end else if (blk_num != want_num && blk_num != last_ok) begin
              r.send_code = SEND_CAN;
              r.status    = ST_SYNC;
              ph          = PH_END;
            end else if (!good) begin
              r.send_code = SEND_NAK;
            end else begin
              r.send_code = SEND_ACK;
              if (fresh) begin
                r.block_commit = 1'b1;
                last_ok        = want_num;
              end
            end
          end
        end
        default: ;  // idle or finished: byte ignored
      endcase
    end
  endtask

  // Channel monitor: replies first, then the new item, then the check mode
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      clear_transfer();
      ph       = PH_IDLE;
      crc_mode = 1'b1;
      reply_q.delete();
      end_checked = 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (reply_q.size() == 0) begin
          report_mismatch("reply transfer with nothing expected");
        end else begin
          want = reply_q.pop_front();
          cmp_field("send_code", 8'(result.send_code), 8'(want.send_code));
          cmp_field("data_valid", 8'(result.data_valid), 8'(want.data_valid));
          cmp_field("data_byte", result.data_byte, want.data_byte);
          cmp_field("block_end", 8'(result.block_end), 8'(want.block_end));
          cmp_field("block_commit", 8'(result.block_commit), 8'(want.block_commit));
          cmp_field("status", 8'(result.status), 8'(want.status));
          if (want.block_commit) begin
            commits++;
          end
        end
        n_replies++;
      end
      if (item_valid && !item_stall) begin
        predict_reply(item, want);
        reply_q.push_back(want);
      end
      if (cfg_we) begin
        crc_mode = cfg_wdata;
      end
      if (run_done && !end_checked) begin
        end_checked = 1'b1;
        if (reply_q.size() != 0) begin
          report_mismatch($sformatf("%0d replies never arrived", reply_q.size()));
        end
      end
    end
    pending <= reply_q.size();
  end

endmodule

// File: tb/xmodem_block_receiver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xmodem_block_receiver_tb
// Drives start commands and line bytes into the XMODEM block receiver: a short
// directed pass over the protocol corners, then random transfers made mostly
// of well-formed blocks with random data, mixed with bad headers, bad checks,
// duplicates, sync loss, EOT endings, noise and check-mode switches. Both
// sides idle at random. A checker module predicts and compares every reply.
// ----------------------------------------------------------------------------
module xmodem_block_receiver_tb;
  import xbr_pkg::*;

  localparam logic ACT_BYTE    = ~ACT_START;
  localparam int   ITEM_GOAL   = 1500;
  localparam int   CYCLE_LIMIT = 1000000;

  logic    clk = 1'b0;
  logic    rst;
  logic    cfg_we;
  logic    cfg_wdata;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  logic    run_done;

  int pending;
  int fail_count;
  int commits;

  int   cyc = 0;
  int   stall_left = 0;
  logic calm;

  // Stimulus bookkeeping
  logic       cur_crc;
  logic       live;
  logic [7:0] last_num;
  int         n_items;
  int         n_blocks;
  int         n_sessions;
  int         n_cfg;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  xmodem_block_receiver u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  xmodem_rx_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .run_done     (run_done),
    .pending      (pending),
    .fail_count   (fail_count),
    .commits      (commits)
  );

  // Periodic stretches where neither side idles
  assign calm = (cyc % 1500) < 200;

  // Cycle counter and run limit
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("[xmodem_block_receiver] ERROR");
      $finish;
    end
  end

  // Reply-side stall: mostly short bursts, a few long holds
  always @(posedge clk) begin : stall_gen
    int r;
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      result_stall <= 1'b1;
    end else if (calm) begin
      result_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        result_stall <= 1'b0;
      end else if (r < 97) begin
        result_stall <= 1'b1;
        stall_left   <= $urandom_range(0, 3);
      end else begin
        result_stall <= 1'b1;
        stall_left   <= $urandom_range(15, 40);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // CRC-16 used to build good frames
  function automatic logic [15:0] frame_crc(input logic [15:0] c, input logic [7:0] d);
    c = c ^ {d, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // One item transfer, then a random gap
  task automatic put_item(input logic act, input logic [7:0] b);
    item_t nxt;
    int    gap;
    nxt.action  = act;
    nxt.rx_byte = b;
    item_valid <= 1'b1;
    item       <= nxt;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (live) begin
      n_items++;
    end
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic line_byte(input logic [7:0] b);
    put_item(ACT_BYTE, b);
  endtask

  task automatic start_transfer();
    put_item(ACT_START, 8'($urandom));
    live     = 1'b1;
    last_num = '0;
    n_sessions++;
  endtask

  // Hold the sender until every reply has come back
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_crc = v;
    n_cfg++;
  endtask

  // Send a block; cut stops it early, flip_at switches check mode before that position
  task automatic send_block(input logic [7:0] num, input logic [7:0] hdr_err,
                            input logic chk_err, input int cut, input int flip_at);
    logic [7:0]  hdr[3];
    logic [15:0] crc;
    logic [7:0]  sum;
    logic [7:0]  d;
    hdr[0] = SOH_BYTE;
    hdr[1] = num;
    hdr[2] = ~num ^ hdr_err;
    crc    = '0;
    sum    = '0;
    n_blocks++;
    for (int p = 0; p < 3; p++) begin
      if (p == cut) return;
      if (p == flip_at) write_cfg(~cur_crc);
      line_byte(hdr[p]);
    end
    for (int p = 3; p < 3 + BLOCK_BYTES; p++) begin
      if (p == cut) return;
      if (p == flip_at) write_cfg(~cur_crc);
      case ($urandom_range(0, 15))
        0:       d = 8'h00;
        1:       d = 8'hFF;
        default: d = 8'($urandom);
      endcase
      crc = frame_crc(crc, d);
      sum = sum + d;
      line_byte(d);
    end
    if (cut >= 3 + BLOCK_BYTES) return;
    if (flip_at == 3 + BLOCK_BYTES) write_cfg(~cur_crc);
    if (cur_crc) begin
      line_byte(crc[15:8]);
      if (flip_at == 4 + BLOCK_BYTES) write_cfg(~cur_crc);
      line_byte(crc[7:0] ^ {7'd0, chk_err});
    end else begin
      line_byte(sum ^ {7'd0, chk_err});
    end
  endtask

  initial begin : stimulus
    int         r;
    int         flip;
    logic       bad;
    logic [7:0] b;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = 1'b0;
    item_valid = 1'b0;
    item       = '0;
    run_done   = 1'b0;
    cur_crc    = 1'b1;
    live       = 1'b0;
    last_num   = '0;
    n_items    = 0;
    n_blocks   = 0;
    n_sessions = 0;
    n_cfg      = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: bytes before any start are ignored
    line_byte(8'h00);
    line_byte(8'hFF);
    line_byte(SOH_BYTE);
    // EOT, EOT: clean finish, then a byte after done
    start_transfer();
    line_byte(EOT_BYTE);
    line_byte(EOT_BYTE);
    live = 1'b0;
    line_byte(8'h55);
    // EOT then something else
    start_transfer();
    line_byte(EOT_BYTE);
    line_byte(8'hFF);
    // junk while waiting for a block
    start_transfer();
    line_byte(8'h00);
    // checksum mode: restart twice, restart mid-block, restart after EOT
    write_cfg(1'b0);
    start_transfer();
    start_transfer();
    line_byte(SOH_BYTE);
    line_byte(8'h01);
    line_byte(8'hFE);
    line_byte(8'hA5);
    start_transfer();
    line_byte(EOT_BYTE);
    start_transfer();
    line_byte(8'h80);
    write_cfg(1'b1);
    live = 1'b0;

    // Random transfers
    while (n_items < ITEM_GOAL) begin
      if (!live) begin
        repeat ($urandom_range(0, 2)) line_byte(8'($urandom));
        if ($urandom_range(0, 3) == 0) begin
          write_cfg(1'($urandom_range(0, 1)));
        end
        start_transfer();
      end
      r = $urandom_range(0, 99);
      if (r < 52) begin
        // next block in sequence, sometimes with a check-mode switch inside
        bad  = $urandom_range(0, 9) == 0;
        flip = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 4 + BLOCK_BYTES) : -1;
        send_block(last_num + 8'd1, 8'h00, bad, -1, flip);
        if (flip >= 0) begin
          live = 1'b0;
        end else if (!bad) begin
          last_num = last_num + 8'd1;
        end
      end else if (r < 62) begin
        // repeat of the last good block
        send_block(last_num, 8'h00, $urandom_range(0, 4) == 0, -1, -1);
      end else if (r < 69) begin
        send_block(8'($urandom), 8'($urandom_range(1, 255)), 1'b0, -1, -1);
      end else if (r < 73) begin
        // block number out of sequence
        send_block(last_num + 8'($urandom_range(2, 255)), 8'h00, 1'b0, -1, -1);
        live = 1'b0;
      end else if (r < 78) begin
        send_block(last_num + 8'd1, 8'h00, 1'b0, $urandom_range(1, 3 + BLOCK_BYTES), -1);
        start_transfer();
      end else if (r < 86) begin
        line_byte(EOT_BYTE);
        r = $urandom_range(0, 9);
        if (r < 7) begin
          line_byte(EOT_BYTE);
          live = 1'b0;
        end else if (r < 9) begin
          b = 8'($urandom);
          line_byte((b == EOT_BYTE) ? 8'h00 : b);
          live = 1'b0;
        end else begin
          start_transfer();
        end
      end else if (r < 91) begin
        b = 8'($urandom);
        line_byte((b == SOH_BYTE || b == EOT_BYTE) ? 8'hFF : b);
        live = 1'b0;
      end else if (r < 96) begin
        start_transfer();
      end else begin
        drain();
      end
    end

    // Wind down
    drain();
    repeat (8) @(posedge clk);
    run_done <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    $display("covered %0d line items in %0d transfers, %0d blocks sent, %0d committed",
             n_items, n_sessions, n_blocks, commits);
    $display("check mode written %0d times, both sides stalling at random", n_cfg);
    if (fail_count == 0) begin
      $display("[xmodem_block_receiver] OK");
    end else begin
      $display("[xmodem_block_receiver] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/xbr_pkg.sv
hw/rtl/xbr_front.sv
hw/rtl/xbr_queue.sv
hw/rtl/xbr_back.sv
hw/rtl/xmodem_block_receiver.sv
tb/xmodem_rx_checker.sv
tb/xmodem_block_receiver_tb.sv
